// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check, off while reset is asserted.
`define ASSERT_CHK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define ASSERT_ALW(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CHK(lbl, clk, rstn, prop, msg)
`define ASSERT_ALW(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/gcl_pkg.sv =====
package gcl_pkg;

	// Operand field width on the ports and active operand width.
	localparam int FIELD_W = 32;
	localparam int OP_W    = 32;
	localparam int RES_W   = 64;

	// Divider step counter width.
	localparam int CNT_W = (OP_W > 1) ? $clog2(OP_W) : 1;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// ===== rtl/gcl_if.sv =====
interface gcl_req_if;
	import gcl_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      mode;
	logic signed [FIELD_W-1:0] first_value;
	logic signed [FIELD_W-1:0] second_value;

	modport source (output valid, output mode, output first_value, output second_value,
		input ready);
	modport sink (input valid, input mode, input first_value, input second_value,
		output ready);
endinterface

interface gcl_rsp_if;
	import gcl_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [RES_W-1:0] result;
	logic                    divide_by_zero;

	modport source (output valid, output result, output divide_by_zero, input ready);
	modport sink (input valid, input result, input divide_by_zero, output ready);
endinterface

// ===== rtl/gcl_div.sv =====
`include "assert_macros.svh"

// Restoring bit-serial divider on unsigned magnitudes, one quotient bit per cycle.
module gcl_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [gcl_pkg::OP_W-1:0]  dividend,
	input  logic [gcl_pkg::OP_W-1:0]  divisor,
	output gcl_pkg::div_sts_t         sts,
	output logic [gcl_pkg::OP_W-1:0]  quot,
	output logic [gcl_pkg::OP_W-1:0]  rem
);
	import gcl_pkg::*;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OP_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [OP_W-1:0]  q_q;
	logic [OP_W-1:0]  r_q;
	logic [OP_W-1:0]  d_q;

	logic [OP_W:0] trial;
	logic [OP_W:0] diff;
	logic          fits;

	assign trial = {r_q, q_q[OP_W-1]};
	assign diff  = trial - {1'b0, d_q};
	assign fits  = ~diff[OP_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_LAST;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			q_q <= {q_q[OP_W-2:0], fits};
			r_q <= fits ? diff[OP_W-1:0] : trial[OP_W-1:0];
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quot     = q_q;
	assign rem      = r_q;

	`ASSERT_CHK(a_div_done_pulse, clk, arst_n, done_q |=> !done_q, "div done held")
	`ASSERT_CHK(a_div_no_restart, clk, arst_n, start |-> !busy_q, "div restarted while busy")
	`ASSERT_CHK(a_div_rem_lt, clk, arst_n, done_q |-> (r_q < d_q), "div remainder too large")
endmodule

// ===== rtl/euclid_gcd_lcm_unit.sv =====
// Euclidean GCD / LCM unit.
// req channel: one word carries mode (0 = gcd, 1 = lcm) and two signed 32-bit operands,
// taken when req.valid and req.ready are both high. rsp channel: one word per request,
// the signed 64-bit result and divide_by_zero (lcm asked with both operands zero).
// One request is worked at a time; req.ready is high only while the sequencer is idle.
// Each Euclid remainder step runs on one shared bit-serial divider, which produces the
// quotient bits serially; the sequencer tests b between steps. A gcd takes one divider
// pass per remainder step, up to about 46 steps; lcm adds one more divider pass, |a| / gcd,
// whose quotient is multiplied by |b| (32x32) as it finishes, and one sign step. The
// divider's serial loop and the step count bound the rate of words; small or closely
// related operands finish far sooner.
// The finished word lands in an output register, so the next request is taken while the
// previous result still waits. If rsp stays stalled when the next result is ready,
// the sequencer holds it in the finish state until the output register frees up.
// Reset (arst_n low) clears the sequencer and the output valid at once; no other state
// persists between words.
`include "assert_macros.svh"

module euclid_gcd_lcm_unit (
	input logic     clk,
	input logic     arst_n,
	gcl_req_if.sink req,
	gcl_rsp_if.source rsp
);
	import gcl_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_STEP = 6'b000010, // test b, launch next division
		ST_EDIV = 6'b000100, // Euclid remainder in flight
		ST_LDIV = 6'b001000, // |a| / gcd in flight
		ST_LSGN = 6'b010000, // apply lcm sign
		ST_FIN  = 6'b100000  // hand result to output register
	} state_t;

	state_t state_q;

	// Working pair as sign + magnitude; truncated remainder takes the dividend's sign.
	logic             mode_q;
	logic [OP_W-1:0]  a_mag_q;
	logic             a_neg_q;
	logic [OP_W-1:0]  b_mag_q;
	logic             b_neg_q;
	logic [OP_W-1:0]  oa_mag_q;   // original |a|, lcm dividend
	logic [OP_W-1:0]  ob_mag_q;   // original |b|, lcm multiplier
	logic             lsgn_q;
	logic [RES_W-1:0] prod_q;
	logic [RES_W-1:0] pend_res_q;
	logic             pend_dz_q;

	logic             ov_q;
	logic [RES_W-1:0] res_q;
	logic             dz_q;

	// Operand unpack: low OP_W bits, sign from bit OP_W-1.
	logic [OP_W-1:0] op_a;
	logic [OP_W-1:0] op_b;
	logic [OP_W-1:0] op_a_mag;
	logic [OP_W-1:0] op_b_mag;

	assign op_a     = req.first_value[OP_W-1:0];
	assign op_b     = req.second_value[OP_W-1:0];
	assign op_a_mag = op_a[OP_W-1] ? (~op_a + 1'b1) : op_a;
	assign op_b_mag = op_b[OP_W-1] ? (~op_b + 1'b1) : op_b;

	// Shared divider.
	logic            div_start;
	logic [OP_W-1:0] div_dividend;
	logic [OP_W-1:0] div_divisor;
	div_sts_t        div_sts;
	logic [OP_W-1:0] div_quot;
	logic [OP_W-1:0] div_rem;

	logic b_zero;
	logic a_zero;
	assign b_zero = (b_mag_q == '0);
	assign a_zero = (a_mag_q == '0);

	// b nonzero: Euclid step a rem b. b zero in lcm mode: |a_orig| / gcd.
	assign div_start    = (state_q == ST_STEP) && (!b_zero || (mode_q && !a_zero));
	assign div_dividend = b_zero ? oa_mag_q : a_mag_q;
	assign div_divisor  = b_zero ? a_mag_q  : b_mag_q;

	gcl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.sts      (div_sts),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// gcd with its sign, one bit wider so that the most negative value fits as magnitude.
	logic [OP_W:0]     gcd_ext;
	logic [2*OP_W-1:0] prod_w;

	assign gcd_ext = a_neg_q ? (~{1'b0, a_mag_q} + 1'b1) : {1'b0, a_mag_q};
	assign prod_w  = div_quot * ob_mag_q;

	logic out_free;
	logic out_load;
	assign out_free = !ov_q || rsp.ready;
	assign out_load = (state_q == ST_FIN) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q    <= 1'b0;
		end else begin
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (!b_zero) begin
						state_q <= ST_EDIV;
					end else if (mode_q && !a_zero) begin
						state_q <= ST_LDIV;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_EDIV: begin
					if (div_sts.done) begin
						state_q <= ST_STEP;
					end
				end
				ST_LDIV: begin
					if (div_sts.done) begin
						state_q <= ST_LSGN;
					end
				end
				ST_LSGN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			mode_q   <= req.mode;
			a_mag_q  <= op_a_mag;
			a_neg_q  <= op_a[OP_W-1];
			b_mag_q  <= op_b_mag;
			b_neg_q  <= op_b[OP_W-1];
			oa_mag_q <= op_a_mag;
			ob_mag_q <= op_b_mag;
			lsgn_q   <= op_a[OP_W-1] ^ op_b[OP_W-1];
		end
		if (state_q == ST_STEP && b_zero) begin
			// Loop finished: a holds the signed gcd.
			lsgn_q <= lsgn_q ^ a_neg_q;
			if (!mode_q) begin
				pend_res_q <= RES_W'($signed(gcd_ext));
				pend_dz_q  <= 1'b0;
			end else begin
				// lcm with zero gcd flags; otherwise overwritten after the division.
				pend_res_q <= '0;
				pend_dz_q  <= a_zero;
			end
		end
		if (state_q == ST_EDIV && div_sts.done) begin
			a_mag_q <= b_mag_q;
			a_neg_q <= b_neg_q;
			b_mag_q <= div_rem;
			b_neg_q <= a_neg_q;
		end
		if (state_q == ST_LDIV && div_sts.done) begin
			prod_q <= RES_W'(prod_w);
		end
		if (state_q == ST_LSGN) begin
			pend_res_q <= lsgn_q ? (~prod_q + 1'b1) : prod_q;
		end
		if (out_load) begin
			res_q <= pend_res_q;
			dz_q  <= pend_dz_q;
		end
	end

	assign req.ready          = (state_q == ST_IDLE);
	assign rsp.valid          = ov_q;
	assign rsp.result         = res_q;
	assign rsp.divide_by_zero = dz_q;

	`ASSERT_CHK(a_div_only_when_free, clk, arst_n, div_start |-> !div_sts.busy,
		"divider launched while busy")
	`ASSERT_CHK(a_euclid_shrinks, clk, arst_n,
		(state_q == ST_EDIV && div_sts.done) |-> (div_rem < b_mag_q),
		"Euclid remainder did not shrink")
	`ASSERT_CHK(a_fin_delivers, clk, arst_n, out_load |=> rsp.valid,
		"finished word not presented")
	`ASSERT_CHK(a_dz_zero_result, clk, arst_n,
		(rsp.valid && rsp.divide_by_zero) |-> (rsp.result == '0),
		"divide_by_zero with nonzero result")
	`ASSERT_ALW(a_reset_idle, clk, !arst_n |=> (state_q == ST_IDLE && !ov_q),
		"reset did not idle the unit")
endmodule

// ===== tb/euclid_gcd_lcm_unit_tb.sv =====
module euclid_gcd_lcm_unit_tb;
	import gcl_pkg::*;

	// Timing
	localparam int HALF_PERIOD    = 10;
	localparam int RESET_CYCLES   = 7;
	// Let the block settle for longer than a worst-case gcd takes.
	localparam int DRAIN_CYCLES   = 2000;
	// About 370 words, even each at worst-case length, stay well inside this limit.
	localparam longint TIMEOUT_CYCLES = 64'd4000000;

	// Mode codes carried on the request word
	localparam logic MODE_GCD = 1'b0;
	localparam logic MODE_LCM = 1'b1;

	// Operand corners at the port width
	localparam logic [FIELD_W-1:0] OPND_MIN = {1'b1, {(FIELD_W-1){1'b0}}};
	localparam logic [FIELD_W-1:0] OPND_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
	localparam logic [FIELD_W-1:0] OPND_M1  = {FIELD_W{1'b1}};

	// Port bits above the active operand width; these are don't-care inside the block
	localparam logic [63:0] ACTIVE_MASK = (64'd1 << OP_W) - 64'd1;
	localparam logic [FIELD_W-1:0] UPPER_MASK = ~ACTIVE_MASK[FIELD_W-1:0];

	// Random phase sizes; the total comes to about 370 words with the directed and pressure tests
	localparam int PHASE_WORDS    = 84;
	localparam int PRESSURE_WORDS = 12;
	localparam int HOLD_LEN       = 3000;

	typedef struct {
		logic signed [RES_W-1:0] result;
		logic                    divide_by_zero;
	} gcd_lcm_word_t;

	logic clk;
	logic arst_n;

	gcl_req_if req_ch ();
	gcl_rsp_if rsp_ch ();

	euclid_gcd_lcm_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Results still owed by the block, oldest first
	gcd_lcm_word_t pending_results[$];
	int            fail_count;

	// Idling controls, changed only by the test tasks at a rising edge
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	// Long receiver hold-off, counted down by the receiver process
	int          hold_cycles;

	logic [FIELD_W-1:0] corner_vals[10];

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Keep the active low bits and sign-extend from the top active bit.
	function automatic longint widen_operand(logic [FIELD_W-1:0] raw);
		logic [63:0] v;
		v = {{(64-FIELD_W){1'b0}}, raw} & ACTIVE_MASK;
		if (v[OP_W-1])
			v = v | ~ACTIVE_MASK;
		return longint'(v);
	endfunction

	// Euclid with truncated remainder; 64-bit working width, so min rem -1 is just 0.
	function automatic longint euclid_gcd(longint a, longint b);
		longint r;
		while (b != 0) begin
			r = a % b;
			a = b;
			b = r;
		end
		return a;
	endfunction

	function automatic gcd_lcm_word_t predict_gcd_lcm(logic mode, logic [FIELD_W-1:0] first_raw,
			logic [FIELD_W-1:0] second_raw);
		gcd_lcm_word_t w;
		longint a;
		longint b;
		longint g;
		a = widen_operand(first_raw);
		b = widen_operand(second_raw);
		g = euclid_gcd(a, b);
		w.divide_by_zero = 1'b0;
		if (mode == MODE_GCD) begin
			w.result = g;
		end else if (g == 0) begin
			// lcm of zero and zero: no divisor
			w.result = '0;
			w.divide_by_zero = 1'b1;
		end else begin
			// product stays within 2^62, no wrap
			w.result = (a * b) / g;
		end
		return w;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic logic [FIELD_W-1:0] fib_term(int n);
		longint p;
		longint q;
		longint t;
		p = 0;
		q = 1;
		for (int i = 0; i < n; i++) begin
			t = p + q;
			p = q;
			q = t;
		end
		return p[FIELD_W-1:0];
	endfunction

	function automatic logic [FIELD_W-1:0] signed_small(int unsigned lim);
		longint v;
		v = $urandom_range(lim);
		if ($urandom_range(1))
			v = -v;
		return v[FIELD_W-1:0];
	endfunction

	function automatic logic [FIELD_W-1:0] random_sign(logic [FIELD_W-1:0] v);
		if ($urandom_range(1))
			return -v;
		return v;
	endfunction

	// Draw an operand pair. Full-range pairs are slow, so most pairs are small or share a factor.
	task automatic pick_pair(output logic [FIELD_W-1:0] a, output logic [FIELD_W-1:0] b);
		int unsigned pct;
		longint g;
		longint x;
		longint y;
		int n;
		pct = $urandom_range(99);
		if (pct < 25) begin
			a = $urandom;
			b = $urandom;
		end else if (pct < 50) begin
			a = signed_small(1000);
			b = signed_small(1000);
		end else if (pct < 78) begin
			// common factor, so gcd and lcm are nontrivial
			g = $urandom_range(1, 40000);
			x = $urandom_range(0, 50000);
			y = $urandom_range(0, 50000);
			a = random_sign(FIELD_W'(g * x));
			b = random_sign(FIELD_W'(g * y));
		end else if (pct < 92) begin
			a = corner_vals[$urandom_range(9)];
			b = ($urandom_range(1)) ? corner_vals[$urandom_range(9)] : FIELD_W'($urandom);
			if ($urandom_range(1)) begin
				{a, b} = {b, a};
			end
		end else begin
			// consecutive Fibonacci terms: the longest Euclid chains
			n = $urandom_range(25, 46);
			a = random_sign(fib_term(n));
			b = random_sign(fib_term(n - 1));
			if ($urandom_range(1)) begin
				{a, b} = {b, a};
			end
		end
		// junk in the unused upper bits, where the port is wider than the operand
		if ($urandom_range(1)) begin
			a = a ^ (FIELD_W'($urandom) & UPPER_MASK);
			b = b ^ (FIELD_W'($urandom) & UPPER_MASK);
		end
	endtask

	// Offer one request word, after a random idle gap, and log its prediction once taken.
	// Returns right after the accepting edge with valid still high, so the next call can
	// follow back to back.
	task automatic offer_operands(logic mode, logic [FIELD_W-1:0] first_raw,
			logic [FIELD_W-1:0] second_raw);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid        <= 1'b1;
		req_ch.mode         <= mode;
		req_ch.first_value  <= first_raw;
		req_ch.second_value <= second_raw;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		pending_results.push_back(predict_gcd_lcm(mode, first_raw, second_raw));
	endtask

	task automatic sender_rest();
		@(negedge clk);
		req_ch.valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stalls, or a counted hold-off when a test asks for one
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			rsp_ch.ready <= 1'b0;
			hold_cycles = hold_cycles - 1;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Result checker: every taken rsp word against the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		gcd_lcm_word_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("rsp word with no request outstanding: result %0d", rsp_ch.result);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.result !== want.result) begin
					$error("result: expected %0d, actual %0d", want.result, rsp_ch.result);
					fail_count++;
				end
				if (rsp_ch.divide_by_zero !== want.divide_by_zero) begin
					$error("divide_by_zero: expected %0b, actual %0b", want.divide_by_zero,
						rsp_ch.divide_by_zero);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Corners and sign rules, every mode, no idling
	task automatic test_directed_corners();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		// gcd of zero and zero gives 0 with no flag; lcm of the same raises the flag
		offer_operands(MODE_GCD, '0, '0);
		offer_operands(MODE_LCM, '0, '0);
		// one operand zero
		offer_operands(MODE_LCM, '0, 32'sd5);
		offer_operands(MODE_LCM, -32'sd7, '0);
		offer_operands(MODE_GCD, '0, -32'sd9);
		offer_operands(MODE_GCD, 32'sd12, '0);
		// sign handling follows truncated arithmetic
		offer_operands(MODE_GCD, 32'sd12, 32'sd18);
		offer_operands(MODE_LCM, 32'sd12, 32'sd18);
		offer_operands(MODE_GCD, -32'sd12, 32'sd18);
		offer_operands(MODE_LCM, -32'sd12, 32'sd18);
		offer_operands(MODE_GCD, 32'sd12, -32'sd18);
		offer_operands(MODE_LCM, -32'sd12, -32'sd18);
		// minimum against minus one: remainder must come out 0
		offer_operands(MODE_GCD, OPND_MIN, OPND_M1);
		offer_operands(MODE_LCM, OPND_MIN, OPND_M1);
		offer_operands(MODE_GCD, OPND_M1, OPND_MIN);
		offer_operands(MODE_GCD, OPND_MIN, OPND_MIN);
		offer_operands(MODE_LCM, OPND_MIN, OPND_MIN);
		offer_operands(MODE_GCD, OPND_MAX, OPND_MIN);
		offer_operands(MODE_LCM, OPND_MAX, OPND_MIN);
		// large coprime pair, so the lcm is their full product; then equal maxima
		offer_operands(MODE_LCM, OPND_MAX, OPND_MAX - 1'b1);
		offer_operands(MODE_GCD, OPND_MAX, OPND_MAX);
		// longest Euclid chain in range
		offer_operands(MODE_GCD, fib_term(46), fib_term(45));
		offer_operands(MODE_LCM, fib_term(46), -fib_term(45));
		// upper port bits must be ignored when the operand is narrower
		offer_operands(MODE_GCD, 32'sd24 | UPPER_MASK, 32'sd36 | (UPPER_MASK & 32'h5555_5555));
	endtask

	// Random words under one idling pattern
	task automatic test_random_phase(int unsigned idle_pct, int unsigned stall_pct, int words);
		logic [FIELD_W-1:0] a;
		logic [FIELD_W-1:0] b;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < words; i++) begin
			pick_pair(a, b);
			offer_operands(logic'($urandom_range(1)), a, b);
		end
	endtask

	// Hold rsp off long enough that the output register and the sequencer both fill and
	// req.ready drops, while the sender keeps offering.
	task automatic test_output_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_cycles    = HOLD_LEN;
		for (int i = 0; i < PRESSURE_WORDS; i++) begin
			offer_operands(logic'($urandom_range(1)), signed_small(200), signed_small(200));
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		fail_count          = 0;
		send_idle_pct       = 0;
		recv_stall_pct      = 0;
		hold_cycles         = 0;
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.mode         = MODE_GCD;
		req_ch.first_value  = '0;
		req_ch.second_value = '0;
		rsp_ch.ready        = 1'b0;
		corner_vals = '{'0, 32'sd1, OPND_M1, 32'sd2, -32'sd2, OPND_MIN, OPND_MIN + 1'b1,
			OPND_MAX, OPND_MAX - 1'b1, 32'sd65536};

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_corners();
		test_random_phase(0, 0, PHASE_WORDS);
		test_random_phase(71, 0, PHASE_WORDS);
		test_random_phase(0, 71, PHASE_WORDS);
		test_output_backpressure();
		test_random_phase(15, 15, PHASE_WORDS);
		sender_rest();

		while (pending_results.size() != 0)
			@(posedge clk);
		// catch any stray word the block might still emit
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Hang guard
	initial begin
		#(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
		$display("TB_ERROR");
		$finish;
	end

endmodule
